// ===== hdl/bst_pkg.sv =====
// Package for the byte stream tokenizer: token kinds, character codes and the
// result record with its constructor. No dependencies.
`default_nettype none

package bst_pkg;

  localparam logic [3:0] KIND_ID      = 4'd0;
  localparam logic [3:0] KIND_STR     = 4'd1;
  localparam logic [3:0] KIND_EQUALS  = 4'd2;
  localparam logic [3:0] KIND_SEMI    = 4'd3;
  localparam logic [3:0] KIND_LPAREN  = 4'd4;
  localparam logic [3:0] KIND_RPAREN  = 4'd5;
  localparam logic [3:0] KIND_LBRACE  = 4'd6;
  localparam logic [3:0] KIND_RBRACE  = 4'd7;
  localparam logic [3:0] KIND_COMMA   = 4'd8;
  localparam logic [3:0] KIND_COMMENT = 4'd9;

  localparam logic [7:0] CH_EQUALS  = 8'h3D;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_QUOTE   = 8'h22;

  typedef struct packed {
    logic       last;
    logic       tend;
    logic       valid;
    logic [7:0] ch;
    logic [3:0] kind;
  } result_t;

  function automatic result_t make_result(input logic [3:0] kind, input logic [7:0] ch,
                                          input logic valid, input logic tend);
    result_t r;
    r.kind  = kind;
    r.ch    = valid ? ch : 8'h00;
    r.valid = valid;
    r.tend  = tend;
    r.last  = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/byte_stream_tokenizer.sv =====
// Byte stream tokenizer: scans one source byte per transaction and streams token bytes.
// Depends on bst_pkg for token kinds, character codes and the result record.
// Each result is written into the registered result queue and leaves it in order from its head.
// Throughput: one input byte per cycle while the result queue has room; a byte that gives two
// results needs an extra output transfer, absorbed by the four-entry result queue.
// Input is taken while the queue has room for two results.
// Reset: synchronous, clears the scan mode and empties the result queue.
`default_nettype none

module byte_stream_tokenizer (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // in_byte[7:0]
  input  wire logic       s_axis_tlast,   // end_of_input
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // char_value[7:0]
  output logic [5:0]      m_axis_tuser,   // token_kind[3:0], char_valid[4], last_of_step[5]
  output logic            m_axis_tlast    // token_end
);

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_ID     = 3'd1,
    MODE_STR    = 3'd2,
    MODE_CFIRST = 3'd3,
    MODE_CREST  = 3'd4
  } mode_t;

  mode_t            mode;
  mode_t            mode_next;
  bst_pkg::result_t queue [4];
  logic [1:0]       wptr;
  logic [1:0]       rptr;
  logic [2:0]       count;

  logic             accept;
  logic             pop;
  logic             is_alnum;
  logic [3:0]       punct;
  logic             idle_has;
  bst_pkg::result_t idle_res;
  mode_t            idle_mode;
  bst_pkg::result_t r0;
  bst_pkg::result_t r1;
  logic [1:0]       n;

  assign accept = s_axis_tvalid && s_axis_tready;
  assign pop    = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = (count <= 3'd2);
  assign m_axis_tvalid = (count != 3'd0);
  assign m_axis_tdata  = queue[rptr].ch;
  assign m_axis_tuser  = {queue[rptr].last, queue[rptr].valid, queue[rptr].kind};
  assign m_axis_tlast  = queue[rptr].tend;

  always_comb begin
    is_alnum = (s_axis_tdata inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]});
    case (s_axis_tdata)
      bst_pkg::CH_EQUALS: punct = bst_pkg::KIND_EQUALS;
      bst_pkg::CH_SEMI:   punct = bst_pkg::KIND_SEMI;
      bst_pkg::CH_LPAREN: punct = bst_pkg::KIND_LPAREN;
      bst_pkg::CH_RPAREN: punct = bst_pkg::KIND_RPAREN;
      bst_pkg::CH_LBRACE: punct = bst_pkg::KIND_LBRACE;
      bst_pkg::CH_RBRACE: punct = bst_pkg::KIND_RBRACE;
      bst_pkg::CH_COMMA:  punct = bst_pkg::KIND_COMMA;
      default:            punct = bst_pkg::KIND_ID;
    endcase

    idle_has  = 1'b0;
    idle_mode = MODE_IDLE;
    idle_res  = bst_pkg::make_result(punct, s_axis_tdata, 1'b1, 1'b1);
    if (is_alnum) begin
      idle_has  = 1'b1;
      idle_mode = MODE_ID;
      idle_res  = bst_pkg::make_result(bst_pkg::KIND_ID, s_axis_tdata, 1'b1, 1'b0);
    end else if (s_axis_tdata == bst_pkg::CH_QUOTE) begin
      idle_mode = MODE_STR;
    end else if (s_axis_tdata == bst_pkg::CH_SLASH) begin
      idle_mode = MODE_CFIRST;
    end else if (punct != bst_pkg::KIND_ID) begin
      idle_has = 1'b1;
    end

    n         = 2'd0;
    r0        = idle_res;
    r1        = idle_res;
    mode_next = mode;
    if (s_axis_tlast) begin
      mode_next = MODE_IDLE;
      case (mode)
        MODE_ID: begin
          n  = 2'd1;
          r0 = bst_pkg::make_result(bst_pkg::KIND_ID, 8'h00, 1'b0, 1'b1);
        end
        MODE_STR: begin
          n  = 2'd1;
          r0 = bst_pkg::make_result(bst_pkg::KIND_STR, 8'h00, 1'b0, 1'b1);
        end
        MODE_CFIRST, MODE_CREST: begin
          n  = 2'd1;
          r0 = bst_pkg::make_result(bst_pkg::KIND_COMMENT, 8'h00, 1'b0, 1'b1);
        end
        default: n = 2'd0;
      endcase
    end else begin
      case (mode)
        MODE_ID: begin
          if (is_alnum) begin
            n  = 2'd1;
            r0 = bst_pkg::make_result(bst_pkg::KIND_ID, s_axis_tdata, 1'b1, 1'b0);
          end else begin
            n         = idle_has ? 2'd2 : 2'd1;
            r0        = bst_pkg::make_result(bst_pkg::KIND_ID, 8'h00, 1'b0, 1'b1);
            mode_next = idle_mode;
          end
        end
        MODE_STR: begin
          n = 2'd1;
          if (s_axis_tdata == bst_pkg::CH_QUOTE) begin
            r0        = bst_pkg::make_result(bst_pkg::KIND_STR, 8'h00, 1'b0, 1'b1);
            mode_next = MODE_IDLE;
          end else begin
            r0 = bst_pkg::make_result(bst_pkg::KIND_STR, s_axis_tdata, 1'b1, 1'b0);
          end
        end
        MODE_CFIRST: mode_next = MODE_CREST;
        MODE_CREST: begin
          if (s_axis_tdata == bst_pkg::CH_NEWLINE) begin
            n         = 2'd1;
            r0        = bst_pkg::make_result(bst_pkg::KIND_COMMENT, 8'h00, 1'b0, 1'b1);
            mode_next = MODE_IDLE;
          end
        end
        default: begin
          n         = idle_has ? 2'd1 : 2'd0;
          mode_next = idle_mode;
        end
      endcase
    end

    if (n == 2'd1) begin
      r0.last = 1'b1;
    end
    if (n == 2'd2) begin
      r1.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= MODE_IDLE;
      wptr  <= 2'd0;
      rptr  <= 2'd0;
      count <= 3'd0;
    end else begin
      if (accept) begin
        mode <= mode_next;
        if (n != 2'd0) begin
          queue[wptr] <= r0;
        end
        if (n == 2'd2) begin
          queue[wptr + 2'd1] <= r1;
        end
        wptr <= wptr + n;
      end
      if (pop) begin
        rptr <= rptr + 2'd1;
      end
      count <= count + (accept ? {1'b0, n} : 3'd0) - (pop ? 3'd1 : 3'd0);
    end
  end

  a_count_bound : assert property (@(posedge clk) disable iff (rst) count <= 3'd4)
    else $error("Result queue count exceeds its depth.");

  a_eoi_idle : assert property (@(posedge clk) disable iff (rst)
    accept && s_axis_tlast |=> mode == MODE_IDLE)
    else $error("End of input did not return the scanner to idle.");

  a_comment_first : assert property (@(posedge clk) disable iff (rst)
    accept && !s_axis_tlast && mode == MODE_CFIRST |=> mode == MODE_CREST && $stable(wptr))
    else $error("First comment byte was not skipped silently.");

endmodule

`default_nettype wire
